FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion shorthands, clocked with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every rising edge outside reset
`define U_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// overlapping implication
`define U_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define U_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/u16u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types and constants of the utf-16 to utf-8 transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned CpW = 21;

  // offset folding 0x10000 - 0xDC00 for a surrogate pair
  localparam logic [CpW-1:0] PairOffset = 21'h002400;

  localparam logic [5:0] HighSurrPrefix = 6'b110110;

  // byte count minus one
  typedef logic [1:0] nbytes_t;

  localparam nbytes_t Len1 = 2'd0;
  localparam nbytes_t Len2 = 2'd1;
  localparam nbytes_t Len3 = 2'd2;
  localparam nbytes_t Len4 = 2'd3;

  typedef struct packed {
    logic [CpW-1:0] cp;
    nbytes_t        nbytes_m1;
  } cp_entry_t;

endpackage

FILE: hdl/u16u8_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_fifo
// short queue of classified code points between front and back
// ----------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u16u8_pkg::cp_entry_t  wr_data_i,
  input  logic                  pop_i,
  output u16u8_pkg::cp_entry_t  rd_data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u16u8_pkg::cp_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == FullCnt);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: hdl/u16u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// takes code units, pairs surrogates and sizes the utf-8 sequence
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  big_endian_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            first_byte_i,
  input  logic [7:0]            second_byte_i,
  input  logic                  final_unit_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output u16u8_pkg::cp_entry_t  q_entry_o
);

  logic [15:0] unit;
  logic        accept;
  logic        is_high;
  logic        hold;
  logic [u16u8_pkg::CpW-1:0] cp;

  // only the low ten bits of a high surrogate carry information
  logic [9:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign unit       = big_endian_i ? {first_byte_i, second_byte_i}
                                   : {second_byte_i, first_byte_i};
  assign is_high    = (unit[15:10] == u16u8_pkg::HighSurrPrefix);
  assign hold       = !held_valid_q && is_high && !final_unit_i;

  // follower is combined whatever its value
  always_comb begin
    if (held_valid_q) begin
      cp = {1'b0, held_q, 10'b0} + {5'b0, unit} + u16u8_pkg::PairOffset;
    end else begin
      cp = {5'b0, unit};
    end
  end

  always_comb begin
    q_entry_o.cp = cp;
    priority if (cp[20:16] != '0) begin
      q_entry_o.nbytes_m1 = u16u8_pkg::Len4;
    end else if (cp[15:11] != '0) begin
      q_entry_o.nbytes_m1 = u16u8_pkg::Len3;
    end else if (cp[10:7] != '0) begin
      q_entry_o.nbytes_m1 = u16u8_pkg::Len2;
    end else begin
      q_entry_o.nbytes_m1 = u16u8_pkg::Len1;
    end
  end

  assign q_push_o = accept && !hold;

  always_comb begin
    held_q_next_defaults: begin
      held_d       = held_q;
      held_valid_d = held_valid_q;
    end
    if (accept) begin
      held_valid_d = hold;
      if (hold) begin
        held_d = unit[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
    end
  end

endmodule

FILE: hdl/u16u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// walks a queued code point out as utf-8 bytes into the output register
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  u16u8_pkg::cp_entry_t  q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       at_end;
  logic [1:0] pos;
  logic [7:0] lead;
  logic [5:0] cont;

  assign load   = !out_valid_q || out_ready_i;
  assign at_end = (idx_q == q_entry_i.nbytes_m1);
  assign pos    = q_entry_i.nbytes_m1 - idx_q;
  assign q_pop_o = load && !q_empty_i && at_end;

  always_comb begin
    unique case (q_entry_i.nbytes_m1)
      u16u8_pkg::Len1: lead = {1'b0, q_entry_i.cp[6:0]};
      u16u8_pkg::Len2: lead = {3'b110, q_entry_i.cp[10:6]};
      u16u8_pkg::Len3: lead = {4'b1110, q_entry_i.cp[15:12]};
      default:         lead = {5'b11110, q_entry_i.cp[20:18]};
    endcase
  end

  // six payload bits per continuation byte, counted from the end
  always_comb begin
    unique case (pos)
      2'd0:    cont = q_entry_i.cp[5:0];
      2'd1:    cont = q_entry_i.cp[11:6];
      default: cont = q_entry_i.cp[17:12];
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = !q_empty_i;
      byte_d      = (idx_q == '0) ? lead : {2'b10, cont};
      last_d      = at_end;
      if (!q_empty_i) begin
        idx_d = at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;

endmodule

FILE: hdl/utf16_to_utf8_transcoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// utf-16 code units in, utf-8 bytes out
// ----------------------------------------------------------------------------
// A code unit word is taken every cycle while the code point queue has room;
// each unit leaves as 1 to 4 utf-8 bytes through a single output register,
// one byte per cycle unless the output stalls; a held high surrogate yields
// none until its follower arrives. The byte-serial output port sets the
// sustained rate. A high surrogate that is not the final unit is held and
// merged with whatever unit comes next; lone and final surrogates go out as
// three-byte forms. tlast marks each code point's last byte. The user must
// write the byte order register only while the block is idle (not enforced).
module utf16_to_utf8_transcoder_core #(
  parameter int unsigned QueueDepth = 2  // at least 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,      // big_endian
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // first_byte, second_byte
  input  logic        s_axis_tlast,    // final_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // out_byte
  output logic        m_axis_tlast     // run_last
);

  logic big_endian_q;
  logic q_push, q_pop, q_empty, q_full;
  u16u8_pkg::cp_entry_t q_wr, q_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_valid_i) begin
      big_endian_q <= cfg_data_i;
    end
  end

  u16u8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .big_endian_i  (big_endian_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .first_byte_i  (s_axis_tdata[7:0]),
    .second_byte_i (s_axis_tdata[15:8]),
    .final_unit_i  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wr)
  );

  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr),
    .pop_i     (q_pop),
    .rd_data_o (q_rd),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .run_last_o  (m_axis_tlast)
  );

endmodule

FILE: hdl/u16u8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_checker
// port-level checks of the transcoder output stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled word holds
  `U_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // ascii byte is always a whole sequence
  `U_ASSERT_IMP(a_ascii_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[7], m_axis_tlast)

  // a multi-byte lead never closes its sequence
  `U_ASSERT_IMP(a_lead_not_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[7:6] == 2'b11), !m_axis_tlast)

  // the rest of a sequence follows without a gap
  `U_ASSERT_NXT(a_cont_follows, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[7:6] == 2'b10))

endmodule

bind utf16_to_utf8_transcoder_core u16u8_checker u_u16u8_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
